/* rtl/psock_pkg.sv */
// psock_pkg: shared types, sizes and codes for the socket table.
// No dependencies; imported by psock_ram, psock_ctrl and port_socket_table.
package psock_pkg;

    localparam int TABLE_SLOTS = 150;

    localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int PORT_W = 16;
    localparam int HDL_W  = 8;
    localparam int SLOT_W = 8;
    localparam int CMP_W  = (CNT_W > HDL_W) ? CNT_W : HDL_W;

    localparam logic [PORT_W-1:0] DYN_FIRST = 16'h4002;
    localparam logic [PORT_W-1:0] DYN_LAST  = 16'h7fff;
    localparam logic [PORT_W-1:0] PORT_FREE = 16'h0000;

    localparam logic [1:0] OP_OPEN   = 2'd0;
    localparam logic [1:0] OP_CLOSE  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ALREADY  = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_CLOSE_CHK,
        ST_SHR_RD,
        ST_SHR_CHK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [PORT_W-1:0] port;
        logic [HDL_W-1:0]  handle;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PORT_W-1:0] port_out;
        logic [SLOT_W-1:0] slot;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [PORT_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

endpackage

/* rtl/psock_ram.sv */
// psock_ram: slot table storage, one write and one read port, registered read.
// Depends on psock_pkg.
module psock_ram
    import psock_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          mem_req,
    output logic [PORT_W-1:0] rd_data
);

    logic [PORT_W-1:0] mem [TABLE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        rd_data <= mem[mem_req.raddr];
    end

endmodule

/* rtl/psock_ctrl.sv */
// psock_ctrl: request sequencer; scans the slot table, allocates, frees, shrinks the count.
// Depends on psock_pkg; drives psock_ram through a mem_req_t.
module psock_ctrl
    import psock_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    output mem_req_t          mem_req,
    input  logic [PORT_W-1:0] rd_data
);

    state_t            state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [PORT_W-1:0] target_reg, target_next;
    logic              dyn_reg, dyn_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]  hdl_idx_reg, hdl_idx_next;
    res_t              res_reg, res_next;

    logic              issue_go;
    logic              hit_now;
    logic              scan_done;
    logic              handle_ok;
    logic [CNT_W-1:0]  last_idx;

    assign issue_go  = issue_reg < used_reg;
    assign hit_now   = pend_reg && (rd_data == target_reg);
    assign scan_done = !issue_go && !pend_reg;
    assign handle_ok = CMP_W'(req.handle) < CMP_W'(used_reg);
    assign last_idx  = used_reg - CNT_W'(1);

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res       = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.op)
                        OP_OPEN:   state_next = ST_SCAN;
                        OP_CLOSE:  state_next = handle_ok ? ST_CLOSE_CHK : ST_RESP;
                        OP_LOOKUP: state_next = (req.port != PORT_FREE) ? ST_SCAN : ST_RESP;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit_now || scan_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (op_reg == OP_OPEN && dyn_reg && hit_reg && target_reg != DYN_LAST)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_CLOSE_CHK: state_next = (rd_data == PORT_FREE) ? ST_RESP : ST_SHR_RD;
            ST_SHR_RD:    state_next = (used_reg == '0) ? ST_RESP : ST_SHR_CHK;
            ST_SHR_CHK:   state_next = (rd_data == PORT_FREE) ? ST_SHR_RD : ST_RESP;
            ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        op_next         = op_reg;
        target_next     = target_reg;
        dyn_next        = dyn_reg;
        used_next       = used_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hdl_idx_next    = hdl_idx_reg;
        res_next        = res_reg;
        mem_req.we      = 1'b0;
        mem_req.waddr   = '0;
        mem_req.wdata   = PORT_FREE;
        mem_req.raddr   = issue_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = req.op;
                    dyn_next        = (req.port == PORT_FREE);
                    target_next     = (req.op == OP_OPEN && req.port == PORT_FREE) ?
                                      DYN_FIRST : req.port;
                    issue_next      = '0;
                    pend_next       = 1'b0;
                    free_found_next = 1'b0;
                    hit_next        = 1'b0;
                    hdl_idx_next    = IDX_W'(req.handle);
                    res_next        = '{STAT_NOTFOUND, PORT_FREE, '0};
                    mem_req.raddr   = IDX_W'(req.handle);
                end
            end
            ST_SCAN:
            begin
                // read of entry i overlaps the compare of entry i-1
                if (issue_go && !hit_now)
                begin
                    mem_req.raddr = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && rd_data == PORT_FREE && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = pend_idx_reg;
                end
                if (hit_now)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = pend_idx_reg;
                end
            end
            ST_EVAL:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    if (hit_reg)
                    begin
                        res_next = '{STAT_OK, PORT_FREE, SLOT_W'(hit_idx_reg)};
                    end
                end
                else if (hit_reg)
                begin
                    if (dyn_reg && target_reg != DYN_LAST)
                    begin
                        // candidate taken: try the next number with a fresh scan
                        target_next     = target_reg + PORT_W'(1);
                        issue_next      = '0;
                        pend_next       = 1'b0;
                        free_found_next = 1'b0;
                        hit_next        = 1'b0;
                    end
                    else
                    begin
                        res_next = '{(dyn_reg ? STAT_FULL : STAT_ALREADY), PORT_FREE, '0};
                    end
                end
                else if (free_found_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = free_idx_reg;
                    mem_req.wdata = target_reg;
                    res_next      = '{STAT_OK, target_reg, SLOT_W'(free_idx_reg)};
                end
                else if (used_reg < CNT_W'(TABLE_SLOTS))
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = used_reg[IDX_W-1:0];
                    mem_req.wdata = target_reg;
                    used_next     = used_reg + CNT_W'(1);
                    res_next      = '{STAT_OK, target_reg, SLOT_W'(used_reg[IDX_W-1:0])};
                end
                else
                begin
                    res_next = '{STAT_FULL, PORT_FREE, '0};
                end
            end
            ST_CLOSE_CHK:
            begin
                if (rd_data != PORT_FREE)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = hdl_idx_reg;
                    mem_req.wdata = PORT_FREE;
                    res_next      = '{STAT_OK, PORT_FREE, '0};
                end
            end
            ST_SHR_RD:
            begin
                mem_req.raddr = last_idx[IDX_W-1:0];
            end
            ST_SHR_CHK:
            begin
                if (rd_data == PORT_FREE)
                begin
                    used_next = last_idx;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        target_reg     <= target_next;
        dyn_reg        <= dyn_next;
        issue_reg      <= issue_next;
        pend_idx_reg   <= pend_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hdl_idx_reg    <= hdl_idx_next;
        res_reg        <= res_next;
    end

endmodule

/* rtl/port_socket_table.sv */
// port_socket_table: top level of the socket number table with stream ports.
// Depends on psock_pkg, psock_ram and psock_ctrl.
//
//  channel   | direction | tdata (low bit first)         | tuser
//  ----------+-----------+-------------------------------+-------------------
//  s_axis    | in        | port[15:0], handle[23:16]     | opcode[1:0]
//  m_axis    | out       | port_out[15:0], slot[23:16]   | status[1:0]
//
// One request at a time. The slot table sits in a single RAM with a registered
// read; scans read one slot per cycle, open and lookup scan the slots below the
// count, dynamic open repeats that scan once per candidate number already in use,
// and close frees the slot, then drops trailing free slots from the count.
// Reset clears the slot count only; slots at or above the count are never read.
// A finished result sits in the output register, so the next request is taken
// while it waits on m_axis_tready.
module port_socket_table
    import psock_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // port[15:0], handle[23:16]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // port_out[15:0], slot[23:16]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    req_t              req;
    res_t              res;
    logic              res_valid;
    logic              res_ready;
    mem_req_t          mem_req;
    logic [PORT_W-1:0] rd_data;

    logic              m_valid_reg, m_valid_next;
    res_t              m_res_reg;

    // unpack the request
    assign req.op     = s_axis_tuser;
    assign req.port   = s_axis_tdata[15:0];
    assign req.handle = s_axis_tdata[23:16];

    psock_ram u_ram
    (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    psock_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    // output register: takes a new result whenever empty or being drained
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_res_reg.slot, m_res_reg.port_out};
    assign m_axis_tuser  = m_res_reg.status;

endmodule
